[rtl/bmmu_pkg.sv]
// ----------------------------------------------------------------------------
// bmmu_pkg
// Shared types and constants of the banked memory unit: bank geometry,
// bus command codes, port numbers and the mapping state handed between
// the port register file and the top level.
// ----------------------------------------------------------------------------
package bmmu_pkg;

  // Bank geometry.
  localparam int BANK_TOTAL = 16;
  localparam int BANK_BYTES = 65536;
  localparam int BANK_W     = (BANK_TOTAL > 1) ? $clog2(BANK_TOTAL) : 1;
  localparam int OFFS_W     = $clog2(BANK_BYTES);
  localparam int MEM_DEPTH  = BANK_TOTAL * BANK_BYTES;
  localparam int MEM_AW     = BANK_W + OFFS_W;

  // Upper limit for the bank count written through the count port.
  localparam logic [8:0] BANK_LIMIT = 9'(BANK_TOTAL);

  // Boundary after reset, in 256-byte pages.
  localparam logic [7:0] RESET_PAGE = 8'((48 * 1024) / 256);

  // Bus commands.
  typedef enum logic [1:0] {
    CMD_MEM_READ   = 2'd0,
    CMD_MEM_WRITE  = 2'd1,
    CMD_PORT_READ  = 2'd2,
    CMD_PORT_WRITE = 2'd3
  } bmmu_cmd_t;

  // Port numbers.
  localparam logic [7:0] PORT_COUNT    = 8'd20;
  localparam logic [7:0] PORT_SELECT   = 8'd21;
  localparam logic [7:0] PORT_BOUNDARY = 8'd22;
  localparam logic [7:0] PORT_PROTECT  = 8'd23;

  // Current mapping, as seen by the address decode.
  typedef struct packed {
    logic [BANK_W-1:0] sel_bank;
    logic              bank_on;
    logic [7:0]        page;
    logic              protect_on;
  } bmmu_map_t;

endpackage

[rtl/bmmu_regs.sv]
// ----------------------------------------------------------------------------
// bmmu_regs
// Port register file: bank count, selected bank, segment boundary page and
// common write protect, with port read-back and the decoded mapping.
// ----------------------------------------------------------------------------
module bmmu_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [7:0]          port,
  input  logic [7:0]          wr_data,
  output logic [7:0]          rd_data,
  output bmmu_pkg::bmmu_map_t map
);

  logic [7:0] bank_count_r, bank_count_nxt;
  logic [7:0] sel_bank_r,   sel_bank_nxt;
  logic [7:0] page_r,       page_nxt;
  logic [7:0] protect_r,    protect_nxt;

  // Next values for a port write; out-of-range values are ignored.
  always_comb begin
    bank_count_nxt = bank_count_r;
    sel_bank_nxt   = sel_bank_r;
    page_nxt       = page_r;
    protect_nxt    = protect_r;
    if (wr_en) begin
      case (port)
        bmmu_pkg::PORT_COUNT: begin
          if ({1'b0, wr_data} < bmmu_pkg::BANK_LIMIT) bank_count_nxt = wr_data;
        end
        bmmu_pkg::PORT_SELECT: begin
          if (wr_data < bank_count_r) sel_bank_nxt = wr_data;
        end
        bmmu_pkg::PORT_BOUNDARY: page_nxt = wr_data;
        bmmu_pkg::PORT_PROTECT:  protect_nxt = wr_data;
        default: ;
      endcase
    end
  end

  // Register state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_count_r <= '0;
      sel_bank_r   <= '0;
      page_r       <= bmmu_pkg::RESET_PAGE;
      protect_r    <= '0;
    end else begin
      bank_count_r <= bank_count_nxt;
      sel_bank_r   <= sel_bank_nxt;
      page_r       <= page_nxt;
      protect_r    <= protect_nxt;
    end
  end

  // Port read-back; unknown ports read zero.
  always_comb begin
    case (port)
      bmmu_pkg::PORT_COUNT:    rd_data = bank_count_r;
      bmmu_pkg::PORT_SELECT:   rd_data = sel_bank_r;
      bmmu_pkg::PORT_BOUNDARY: rd_data = page_r;
      bmmu_pkg::PORT_PROTECT:  rd_data = protect_r;
      default:                 rd_data = '0;
    endcase
  end

  // The selected bank always stays below the bank total, so its low bits
  // are the full bank index.
  assign map.sel_bank   = sel_bank_r[bmmu_pkg::BANK_W-1:0];
  assign map.bank_on    = (sel_bank_r != '0);
  assign map.page       = page_r;
  assign map.protect_on = (protect_r != '0);

endmodule

[rtl/banked_memory_mmu.sv]
// ----------------------------------------------------------------------------
// banked_memory_mmu
// Banked memory unit with a common segment: one bus access per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one bus access: a command,
// a 16-bit address and a write byte. Memory addresses below the segment
// boundary go to the selected bank, those at or above it to bank 0, the
// common area. Ports 20 to 23 hold bank count, selected bank, boundary
// page and write protect.
// Output channel (out_valid / out_stall) returns one read_data byte per
// access, in order; writes and unknown ports return zero.
// An input transfer reaches out_valid through the synchronous bank memory
// read and then the output register. One access is taken every cycle while
// in_stall is low; the bank memory has a single port that serves one read
// or one write per cycle.
// When the receiver stalls, the output register holds its result and a
// second result waits in the memory read stage; only with both full does
// in_stall rise.
// Reset (rst_n low, synchronous) empties both stages and restores the port
// registers: count 0, bank 0, boundary 0xC000, protect off. Bank memory
// is not cleared and holds no defined value until written.
// ----------------------------------------------------------------------------
module banked_memory_mmu (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [15:0] in_address,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);

  bmmu_pkg::bmmu_cmd_t        cmd;
  bmmu_pkg::bmmu_map_t        map;
  logic                       accept;
  logic [7:0]                 port_rdata;
  logic                       port_wr;
  logic                       below;
  logic                       wr_block;
  logic [bmmu_pkg::BANK_W-1:0] bank;
  logic [bmmu_pkg::MEM_AW-1:0] mem_addr;
  logic                       mem_we;
  logic                       mem_re;

  logic [7:0] mem [bmmu_pkg::MEM_DEPTH];
  logic [7:0] mem_rdata_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_is_mem_r;
  logic [7:0] s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_free;
  logic       s1_move;
  logic       out_take;

  assign cmd = bmmu_pkg::bmmu_cmd_t'(in_command);

  // Handshake: the read stage blocks input only when the output is held.
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  // Port registers.
  assign port_wr = accept && (cmd == bmmu_pkg::CMD_PORT_WRITE);

  bmmu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (port_wr),
    .port    (in_address[7:0]),
    .wr_data (in_write_data),
    .rd_data (port_rdata),
    .map     (map)
  );

  // Address decode: below the boundary page the selected bank, else bank 0.
  assign below    = (in_address[15:8] < map.page);
  assign wr_block = !below && map.protect_on;
  assign bank     = (map.bank_on && below) ? map.sel_bank : '0;
  assign mem_addr = {bank, in_address};
  assign mem_we   = accept && (cmd == bmmu_pkg::CMD_MEM_WRITE) && !wr_block;
  assign mem_re   = accept && (cmd == bmmu_pkg::CMD_MEM_READ);

  // Bank memory, one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= in_write_data;
    if (mem_re) mem_rdata_r <= mem[mem_addr];
  end

  // Stage valid flags.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_move) out_valid_nxt = 1'b1;
    else if (out_take) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage payloads: port read data is taken before the register update.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_mem_r <= (cmd == bmmu_pkg::CMD_MEM_READ);
      s1_data_r   <= (cmd == bmmu_pkg::CMD_PORT_READ) ? port_rdata : 8'h00;
    end
    if (s1_move) out_data_r <= s1_is_mem_r ? mem_rdata_r : s1_data_r;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

[rtl/bmmu_checker.sv]
// ----------------------------------------------------------------------------
// bmmu_port_checks
// Port-level checks of the banked memory unit, bound to the top level.
// ----------------------------------------------------------------------------
module bmmu_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_data
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

  // Input is only held back while both result slots are full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a held result");

  // With an empty output and no stall, a transfer reaches out_valid through the read stage and the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) ##1 !out_stall |=> out_valid)
    else $error("result missing after two cycles");

endmodule

bind banked_memory_mmu bmmu_port_checks u_bmmu_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data)
);

[verif/bmmu_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmmu_checker
// Watches both channels of the banked memory unit. Every accepted bus access
// updates a private copy of the mapping registers and of the banked memory,
// and the byte that the access should return is queued. Every accepted result
// is compared with the oldest queued byte.
// ----------------------------------------------------------------------------
module bmmu_checker
  import bmmu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_data,
  output int          mismatch_count,
  output int          reads_outstanding
);

  // One queued result, with the access that caused it for the reports.
  typedef struct {
    bmmu_cmd_t   cmd;
    logic [15:0] addr;
    logic [7:0]  read_data;
  } bus_read_t;

  bus_read_t   read_data_q[$];

  // Private copy of the unit's state.
  logic [7:0]  mem_bytes[int unsigned];
  logic [7:0]  bank_count;
  logic [7:0]  sel_bank;
  logic [7:0]  seg_page;
  logic [7:0]  protect;

  // Applies one bus access to the private state and returns the byte read.
  function automatic logic [7:0] apply_bus_access(bmmu_cmd_t cmd, logic [15:0] addr,
                                                  logic [7:0] data);
    int unsigned loc;
    logic [7:0]  rd;
    rd = '0;
    // Below the boundary the selected bank is used; the common area is bank 0.
    if (sel_bank != 0 && addr[15:8] < seg_page)
      loc = int'(sel_bank) * BANK_BYTES + int'(addr);
    else
      loc = int'(addr);
    case (cmd)
      CMD_MEM_READ: begin
        if (mem_bytes.exists(loc))
          rd = mem_bytes[loc];
      end
      CMD_MEM_WRITE: begin
        // Common area writes are dropped while write protect is set.
        if (!(addr[15:8] >= seg_page && protect != 0))
          mem_bytes[loc] = data;
      end
      CMD_PORT_READ: begin
        case (addr[7:0])
          PORT_COUNT:    rd = bank_count;
          PORT_SELECT:   rd = sel_bank;
          PORT_BOUNDARY: rd = seg_page;
          PORT_PROTECT:  rd = protect;
          default:       rd = '0;
        endcase
      end
      default: begin
        case (addr[7:0])
          PORT_COUNT: begin
            if (9'(data) < BANK_LIMIT)
              bank_count = data;
          end
          PORT_SELECT: begin
            if (data < bank_count)
              sel_bank = data;
          end
          PORT_BOUNDARY: seg_page = data;
          PORT_PROTECT:  protect = data;
          default: ;
        endcase
      end
    endcase
    return rd;
  endfunction

  // Results are checked before the access of the same edge is queued: an
  // access can never produce its result on the edge it is accepted.
  always @(posedge clk) begin
    bus_read_t entry;
    if (!rst_n) begin
      read_data_q.delete();
      bank_count = '0;
      sel_bank   = '0;
      seg_page   = RESET_PAGE;
      protect    = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (read_data_q.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, actual read_data %h",
                   $time, out_read_data);
          mismatch_count++;
        end else begin
          entry = read_data_q.pop_front();
          if (out_read_data !== entry.read_data) begin
            $display("%0t: read_data mismatch (%s at %h): expected %h, actual %h",
                     $time, entry.cmd.name(), entry.addr, entry.read_data, out_read_data);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        entry.cmd       = bmmu_cmd_t'(in_command);
        entry.addr      = in_address;
        entry.read_data = apply_bus_access(entry.cmd, in_address, in_write_data);
        read_data_q.push_back(entry);
      end
    end
    reads_outstanding = read_data_q.size();
  end

endmodule

[verif/banked_memory_mmu_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// banked_memory_mmu_tb
// Drives bus accesses into the banked memory unit: a directed pass over reset
// values, port limits, the segment boundary and write protect, then random
// traffic that reads back only bytes already written under the mapping in
// force. Both channels idle at random; the checker beside the block reports
// mismatches and this module gives the verdict.
// ----------------------------------------------------------------------------
module banked_memory_mmu_tb;
  import bmmu_pkg::*;

  localparam int RANDOM_ACCESSES = 740;
  localparam int STUCK_LIMIT     = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        calm = 1'b0;

  int          mismatch_count;
  int          reads_outstanding;
  int          stuck_cycles = 0;

  // Mapping as the stimulus sees it, used to pick reads of written bytes only.
  logic [7:0]  map_count = '0;
  logic [7:0]  map_bank = '0;
  logic [7:0]  map_page = RESET_PAGE;
  logic [7:0]  map_protect = '0;
  bit          byte_written[int unsigned];
  logic [15:0] written_addrs[$];

  banked_memory_mmu u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

  bmmu_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .mismatch_count    (mismatch_count),
    .reads_outstanding (reads_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, except during calm stretches.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Physical byte that a CPU address reaches under the current mapping.
  function automatic int unsigned mapped_byte(logic [15:0] addr);
    if (map_bank != 0 && addr[15:8] < map_page)
      return int'(map_bank) * BANK_BYTES + int'(addr);
    return int'(addr);
  endfunction

  // Tracks the effect of an accepted access on the mapping and written bytes.
  function automatic void track_access(bmmu_cmd_t cmd, logic [15:0] addr,
                                       logic [7:0] data);
    if (cmd == CMD_MEM_WRITE && !(addr[15:8] >= map_page && map_protect != 0)) begin
      byte_written[mapped_byte(addr)] = 1'b1;
      if (written_addrs.size() >= 512)
        written_addrs[$urandom_range(511)] = addr;
      else
        written_addrs.push_back(addr);
    end else if (cmd == CMD_PORT_WRITE) begin
      case (addr[7:0])
        PORT_COUNT: begin
          if (9'(data) < BANK_LIMIT)
            map_count = data;
        end
        PORT_SELECT: begin
          if (data < map_count)
            map_bank = data;
        end
        PORT_BOUNDARY: map_page = data;
        PORT_PROTECT:  map_protect = data;
        default: ;
      endcase
    end
  endfunction

  // Finds a CPU address whose byte under the current mapping was written.
  function automatic bit pick_written_addr(output logic [15:0] addr);
    logic [15:0] cand;
    addr = '0;
    if (written_addrs.size() == 0)
      return 1'b0;
    repeat (16) begin
      cand = written_addrs[$urandom_range(written_addrs.size() - 1)];
      if (byte_written.exists(mapped_byte(cand))) begin
        addr = cand;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // One access transfer, after a random idle gap; valid stays high between
  // back-to-back transfers.
  task automatic send_access(bmmu_cmd_t cmd, logic [15:0] addr, logic [7:0] data);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 13)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_address    <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    track_access(cmd, addr, data);
  endtask

  // Memory write address: anywhere, around the boundary, or in a small pool.
  function automatic logic [15:0] write_addr();
    case ($urandom_range(3))
      0:       return 16'({map_page, 8'h00} + $urandom_range(7) - 4);
      1:       return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Port write data, mostly values that take effect.
  function automatic logic [7:0] port_data(logic [7:0] port);
    case (port)
      PORT_COUNT: begin
        if ($urandom_range(99) < 75)
          return 8'($urandom_range(BANK_TOTAL - 1, 1));
        return 8'($urandom_range(255));
      end
      PORT_SELECT: begin
        if (map_count != 0 && $urandom_range(99) < 75)
          return 8'($urandom_range(map_count - 1));
        return 8'($urandom_range(255));
      end
      PORT_BOUNDARY: begin
        case ($urandom_range(4))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return RESET_PAGE;
          default: return 8'($urandom_range(255));
        endcase
      end
      default: begin
        if ($urandom_range(1) == 0)
          return 8'h00;
        return 8'($urandom_range(255));
      end
    endcase
  endfunction

  // One random step: mostly writes followed by reads of written bytes.
  task automatic random_access();
    int          pick;
    logic [15:0] addr;
    logic [7:0]  port;
    pick = $urandom_range(99);
    if (pick < 28) begin
      send_access(CMD_MEM_WRITE, write_addr(), 8'($urandom));
    end else if (pick < 60) begin
      if (pick_written_addr(addr))
        send_access(CMD_MEM_READ, addr, 8'($urandom));
      else
        send_access(CMD_MEM_WRITE, write_addr(), 8'($urandom));
    end else if (pick < 72) begin
      // Write then read back at once through the same mapping.
      addr = write_addr();
      send_access(CMD_MEM_WRITE, addr, 8'($urandom));
      if (byte_written.exists(mapped_byte(addr)))
        send_access(CMD_MEM_READ, addr, 8'($urandom));
    end else if (pick < 81) begin
      if ($urandom_range(3) == 0)
        port = 8'($urandom);
      else
        port = 8'($urandom_range(25, 18));
      send_access(CMD_PORT_READ, {8'($urandom), port}, 8'($urandom));
    end else begin
      if ($urandom_range(9) == 0)
        port = 8'($urandom);
      else
        port = 8'($urandom_range(PORT_PROTECT, PORT_COUNT));
      send_access(CMD_PORT_WRITE, {8'($urandom), port}, port_data(port));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values, including a port number with a nonzero upper byte.
    send_access(CMD_PORT_READ, 16'(PORT_COUNT), 8'h00);
    send_access(CMD_PORT_READ, {8'hFF, PORT_BOUNDARY}, 8'hFF);
    send_access(CMD_PORT_READ, 16'h00FF, 8'h00);
    // Bank select beyond a zero count, count limits, then selects at and below the count.
    send_access(CMD_PORT_WRITE, 16'(PORT_SELECT), 8'd1);
    send_access(CMD_PORT_WRITE, 16'(PORT_COUNT), 8'(BANK_TOTAL));
    send_access(CMD_PORT_WRITE, 16'(PORT_COUNT), 8'hFF);
    send_access(CMD_PORT_WRITE, 16'(PORT_COUNT), 8'(BANK_TOTAL - 1));
    send_access(CMD_PORT_WRITE, 16'(PORT_SELECT), 8'(BANK_TOTAL - 1));
    send_access(CMD_PORT_WRITE, 16'(PORT_SELECT), 8'(BANK_TOTAL - 2));
    // Both sides of the boundary and the ends of the address space.
    send_access(CMD_MEM_WRITE, 16'h0000, 8'hFF);
    send_access(CMD_MEM_WRITE, 16'hFFFF, 8'h00);
    send_access(CMD_MEM_WRITE, 16'hBFFF, 8'hA5);
    send_access(CMD_MEM_WRITE, 16'hC000, 8'h5A);
    send_access(CMD_MEM_READ, 16'h0000, 8'h00);
    send_access(CMD_MEM_READ, 16'hBFFF, 8'h00);
    send_access(CMD_MEM_READ, 16'hC000, 8'hFF);
    // A protected common write is dropped.
    send_access(CMD_PORT_WRITE, 16'(PORT_PROTECT), 8'h80);
    send_access(CMD_MEM_WRITE, 16'hFFFF, 8'h77);
    send_access(CMD_MEM_READ, 16'hFFFF, 8'h00);
    send_access(CMD_PORT_WRITE, 16'(PORT_PROTECT), 8'h00);
    // A zero boundary makes everything common; the top page keeps it banked.
    send_access(CMD_PORT_WRITE, 16'(PORT_BOUNDARY), 8'h00);
    send_access(CMD_MEM_WRITE, 16'h0000, 8'h3C);
    send_access(CMD_MEM_READ, 16'h0000, 8'h00);
    send_access(CMD_PORT_WRITE, 16'(PORT_BOUNDARY), 8'hFF);
    send_access(CMD_MEM_READ, 16'h0000, 8'h00);
    // Unknown ports ignore writes and read zero.
    send_access(CMD_PORT_WRITE, 16'd24, 8'hAA);
    send_access(CMD_PORT_READ, 16'd24, 8'h00);

    // Random traffic with a calm stretch in the middle.
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i == 400)
        calm <= 1'b1;
      else if (i == 550)
        calm <= 1'b0;
      random_access();
    end
    in_valid <= 1'b0;

    // Drain, then allow for a stray result after the last expected one. The
    // count is only looked at once the last transfer is in it.
    @(posedge clk);
    while (reads_outstanding != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/bmmu_pkg.sv
rtl/bmmu_regs.sv
rtl/banked_memory_mmu.sv
rtl/bmmu_checker.sv
verif/bmmu_checker.sv
verif/banked_memory_mmu_tb.sv
